// ----- rtl/core/brbps_pkg.sv -----
`default_nettype none
package brbps_pkg;

  localparam int unsigned DEPTH_DEF    = 4096;
  localparam int unsigned MAX_PEEK_DEF = 64;

  // fixed field widths of the stream payloads
  localparam int unsigned IN_CNT_W    = 13;
  localparam int unsigned OUT_CNT_W   = 13;
  localparam int unsigned PLEN_W      = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 40;

  // command queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 3'd0,
    ACT_CONSUME = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_STATUS  = 3'd4
  } action_t;

  typedef enum logic {
    ENT_SINGLE = 1'b0,
    ENT_PEEK   = 1'b1
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t             kind;
    logic                  status;
    logic                  wr_en;
    logic [BYTE_W-1:0]     wr_byte;
    logic [PLEN_W-1:0]     run_len;
    logic [OUT_CNT_W-1:0]  valid_bytes;
    logic [OUT_CNT_W-1:0]  free_bytes;
  } q_meta_t;

endpackage
`default_nettype wire

// ----- rtl/core/brbps_front.sv -----
`default_nettype none
module brbps_front import brbps_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned MAX_PEEK = MAX_PEEK_DEF,
  localparam int unsigned PTR_W   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_block_first,
  input  logic [IN_CNT_W-1:0]  in_block_len,
  input  logic [IN_CNT_W-1:0]  in_skip_amount,
  input  logic [IN_CNT_W-1:0]  in_peek_offset,
  input  logic [PLEN_W-1:0]    in_peek_len,
  output logic                 push,
  output q_meta_t              push_meta,
  output logic [PTR_W-1:0]     push_addr,
  input  logic                 q_full
);

  localparam int unsigned CNT_W = PTR_W + 1;
  localparam int unsigned CMP_W = (CNT_W > IN_CNT_W + 1) ? CNT_W : IN_CNT_W + 1;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] space_r, space_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             blk_acc_r, blk_acc_nxt;

  logic [CNT_W-1:0] space_tmp;
  logic [CNT_W-1:0] head_sum;
  logic [CNT_W-1:0] peek_sum;
  logic [PTR_W-1:0] head_wrap;
  logic [PTR_W-1:0] peek_start;
  logic [PTR_W-1:0] tail_inc;
  logic             peek_bad;
  logic             st;
  logic             wr_en;
  ent_kind_t        kind;
  logic [PLEN_W-1:0] run_len;
  logic [PTR_W-1:0] addr_sel;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign space_tmp = space_r + left_r;
  assign head_sum  = CNT_W'(head_r) + CNT_W'(in_skip_amount);
  assign peek_sum  = CNT_W'(head_r) + CNT_W'(in_peek_offset);
  assign head_wrap = (head_sum >= CNT_W'(DEPTH)) ? PTR_W'(head_sum - CNT_W'(DEPTH))
                                                 : PTR_W'(head_sum);
  assign peek_start = (peek_sum >= CNT_W'(DEPTH)) ? PTR_W'(peek_sum - CNT_W'(DEPTH))
                                                  : PTR_W'(peek_sum);
  assign tail_inc = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign peek_bad = (in_peek_len == '0) || (in_peek_len > PLEN_W'(MAX_PEEK)) ||
                    (CMP_W'(in_peek_offset) + CMP_W'(in_peek_len) > CMP_W'(held_r));

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    held_nxt    = held_r;
    space_nxt   = space_r;
    left_nxt    = left_r;
    blk_acc_nxt = blk_acc_r;
    st          = 1'b0;
    wr_en       = 1'b0;
    kind        = ENT_SINGLE;
    run_len     = PLEN_W'(1);
    addr_sel    = tail_r;
    case (action_t'(in_action))
      ACT_WRITE: begin
        if (in_block_first) begin
          // return the unwritten part of the old reservation first
          space_nxt = space_tmp;
          left_nxt  = '0;
          if (CMP_W'(in_block_len) > CMP_W'(space_tmp)) begin
            blk_acc_nxt = 1'b0;
          end else begin
            blk_acc_nxt = 1'b1;
            space_nxt   = space_tmp - CNT_W'(in_block_len);
            left_nxt    = CNT_W'(in_block_len);
          end
        end
        if (!blk_acc_nxt) begin
          st = 1'b1;
        end else if (left_nxt == '0) begin
          st = !in_block_first;
        end else begin
          wr_en    = 1'b1;
          tail_nxt = tail_inc;
          held_nxt = held_r + 1'b1;
          left_nxt = left_nxt - 1'b1;
        end
      end
      ACT_CONSUME: begin
        if (CMP_W'(in_skip_amount) > CMP_W'(held_r)) begin
          st = 1'b1;
        end else begin
          head_nxt  = head_wrap;
          held_nxt  = held_r - CNT_W'(in_skip_amount);
          space_nxt = space_r + CNT_W'(in_skip_amount);
        end
      end
      ACT_PEEK: begin
        if (peek_bad) begin
          st = 1'b1;
        end else begin
          kind     = ENT_PEEK;
          run_len  = in_peek_len;
          addr_sel = peek_start;
        end
      end
      ACT_CLEAR: begin
        head_nxt    = '0;
        tail_nxt    = '0;
        held_nxt    = '0;
        space_nxt   = CNT_W'(DEPTH);
        left_nxt    = '0;
        blk_acc_nxt = 1'b0;
      end
      ACT_STATUS: begin
        st = 1'b0;
      end
      default: begin
        st = 1'b1;
      end
    endcase
  end

  always_comb begin
    push_meta.kind        = kind;
    push_meta.status      = st;
    push_meta.wr_en       = wr_en;
    push_meta.wr_byte     = in_data_byte;
    push_meta.run_len     = run_len;
    push_meta.valid_bytes = OUT_CNT_W'(held_nxt);
    push_meta.free_bytes  = OUT_CNT_W'(space_nxt);
    push_addr             = addr_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      held_r    <= '0;
      space_r   <= CNT_W'(DEPTH);
      left_r    <= '0;
      blk_acc_r <= 1'b0;
    end else if (push) begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      held_r    <= held_nxt;
      space_r   <= space_nxt;
      left_r    <= left_nxt;
      blk_acc_r <= blk_acc_nxt;
    end
  end

  a_space_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(held_r) + (CNT_W+1)'(space_r) + (CNT_W+1)'(left_r) == (CNT_W+1)'(DEPTH))
    else $error("held, free and reserved bytes do not add up to the ring size");

  a_left_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
    left_r != '0 |-> blk_acc_r)
    else $error("bytes reserved without an accepted block");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_action == ACT_CLEAR |=> held_r == '0 && space_r == CNT_W'(DEPTH) &&
                                       head_r == tail_r)
    else $error("clear did not empty the ring");

endmodule
`default_nettype wire

// ----- rtl/core/brbps_queue.sv -----
`default_nettype none
module brbps_queue import brbps_pkg::*; #(
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  q_meta_t           push_meta,
  input  logic [ADDR_W-1:0] push_addr,
  output logic              full,
  output logic              q_valid,
  output q_meta_t           q_meta,
  output logic [ADDR_W-1:0] q_addr,
  input  logic              pop
);

  q_meta_t           meta_r [Q_DEPTH];
  logic [ADDR_W-1:0] addr_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign full    = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_meta  = meta_r[rd_ptr_r];
  assign q_addr  = addr_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      meta_r[wr_ptr_r] <= push_meta;
      addr_r[wr_ptr_r] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_PTR_W+1)'(Q_DEPTH) && !(pop && !q_valid))
    else $error("command queue overrun or underrun");

endmodule
`default_nettype wire

// ----- rtl/core/brbps_back.sv -----
`default_nettype none
module brbps_back import brbps_pkg::*; #(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  localparam int unsigned PTR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  q_meta_t              q_meta,
  input  logic [PTR_W-1:0]     q_addr,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_status,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_last,
  output logic [OUT_CNT_W-1:0] out_valid_bytes,
  output logic [OUT_CNT_W-1:0] out_free_bytes
);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [PLEN_W-1:0]    beat_r, beat_nxt;
  logic [PTR_W-1:0]     addr_r, addr_nxt;
  logic [PTR_W-1:0]     rd_addr;
  logic [BYTE_W-1:0]    rd_data_r;
  logic                 out_valid_r;
  logic                 status_r;
  logic                 last_r;
  logic                 peek_r;
  logic [OUT_CNT_W-1:0] valid_bytes_r;
  logic [OUT_CNT_W-1:0] free_bytes_r;
  logic                 issue;
  logic                 is_peek;
  logic                 beat_last;

  // launch a transfer whenever the output register is free or being emptied
  assign issue     = q_valid && (!out_valid_r || out_ready);
  assign is_peek   = (q_meta.kind == ENT_PEEK);
  assign beat_last = !is_peek || (beat_r + 1'b1 == q_meta.run_len);
  assign pop       = issue && beat_last;
  assign rd_addr   = (beat_r == '0) ? q_addr : addr_r;

  always_comb begin
    beat_nxt = beat_r;
    addr_nxt = addr_r;
    if (issue && is_peek) begin
      beat_nxt = beat_last ? '0 : beat_r + 1'b1;
      addr_nxt = (rd_addr == PTR_W'(DEPTH - 1)) ? '0 : rd_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && q_meta.wr_en) begin
      mem[q_addr] <= q_meta.wr_byte;
    end
    if (issue && is_peek) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (issue) begin
      status_r      <= q_meta.status;
      last_r        <= beat_last;
      peek_r        <= is_peek;
      valid_bytes_r <= q_meta.valid_bytes;
      free_bytes_r  <= q_meta.free_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_last        = last_r;
  assign out_read_byte   = peek_r ? rd_data_r : '0;
  assign out_valid_bytes = valid_bytes_r;
  assign out_free_bytes  = free_bytes_r;

  a_beat_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && is_peek |-> beat_r < q_meta.run_len)
    else $error("peek beat counter ran past the run length");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> beat_r == '0)
    else $error("peek beat counter left mid-run with no command");

endmodule
`default_nettype wire

// ----- rtl/core/byte_ring_buffer_peek_skip.sv -----
`default_nettype none
// Circular byte buffer with peek and skip. The front end accepts one item per
// cycle, checks it against the held and free counts and updates the ring
// pointers at once; accepted work goes through a four-entry command queue to
// the back end, which owns the single-port byte store. Each byte write,
// consume, clear, status query or refused item gives one result; an
// accepted peek of length L gives L bytes, one byte per cycle from the
// store's one read port while the output is not stalled, and its last byte
// carries tlast. The input stays ready while the queue has room, so short
// items flow at one per cycle and a peek run holds the input off only once
// the queue has filled. Results are registered once the head command issues.
// The store is not cleared after reset; no clearing pass is needed.
module byte_ring_buffer_peek_skip import brbps_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned MAX_PEEK = MAX_PEEK_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // data_byte[7:0], block_len[20:8], skip_amount[33:21], peek_offset[46:34],
  // peek_len[53:47], zero pad[55:54]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[2:0], block_first[3]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_byte[7:0], valid_bytes[20:8], free_bytes[33:21], zero pad[39:34]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[0]
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic                 push;
  q_meta_t              push_meta;
  logic [PTR_W-1:0]     push_addr;
  logic                 q_full;
  logic                 q_valid;
  q_meta_t              q_meta;
  logic [PTR_W-1:0]     q_addr;
  logic                 pop;
  logic [BYTE_W-1:0]    rd_byte;
  logic [OUT_CNT_W-1:0] valid_bytes;
  logic [OUT_CNT_W-1:0] free_bytes;

  brbps_front #(
    .DEPTH    (DEPTH),
    .MAX_PEEK (MAX_PEEK)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_action      (in_tuser[2:0]),
    .in_data_byte   (in_tdata[7:0]),
    .in_block_first (in_tuser[3]),
    .in_block_len   (in_tdata[20:8]),
    .in_skip_amount (in_tdata[33:21]),
    .in_peek_offset (in_tdata[46:34]),
    .in_peek_len    (in_tdata[53:47]),
    .push           (push),
    .push_meta      (push_meta),
    .push_addr      (push_addr),
    .q_full         (q_full)
  );

  brbps_queue #(
    .ADDR_W (PTR_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_meta (push_meta),
    .push_addr (push_addr),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_meta    (q_meta),
    .q_addr    (q_addr),
    .pop       (pop)
  );

  brbps_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_meta          (q_meta),
    .q_addr          (q_addr),
    .pop             (pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (out_tuser),
    .out_read_byte   (rd_byte),
    .out_last        (out_tlast),
    .out_valid_bytes (valid_bytes),
    .out_free_bytes  (free_bytes)
  );

  assign out_tdata = {6'b0, free_bytes, valid_bytes, rd_byte};

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import brbps_pkg::*;

  localparam int     RAND_ITEMS  = 220;
  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint LIMIT_NS    = 64'd600_000_000;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  // action codes the package leaves unnamed; the block must refuse them
  localparam logic [ACTION_W-1:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [BYTE_W-1:0]    data;
    logic                 first;
    logic [IN_CNT_W-1:0]  blen;
    logic [IN_CNT_W-1:0]  skip;
    logic [IN_CNT_W-1:0]  poff;
    logic [PLEN_W-1:0]    plen;
  } cmd_t;

  typedef struct packed {
    logic                 st;
    logic [BYTE_W-1:0]    rbyte;
    logic                 last;
    logic [OUT_CNT_W-1:0] vb;
    logic [OUT_CNT_W-1:0] fb;
  } res_t;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t fixed;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  byte_ring_buffer_peek_skip dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // ring state as the block should hold it
  logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
  int   rd_ptr, wr_ptr, held_cnt, free_cnt, blk_left;
  bit   blk_open;
  res_t run_res [MAX_PEEK_DEF];

  res_t due_results [$];
  row_t dir_rows [$];

  int  faults, items_in, checked, peek_runs, refusals, wraps, held_off;
  bit  hold_rx, tx_steady;

  function automatic res_t mk_res(logic st, logic [BYTE_W-1:0] b, logic last);
    res_t r;
    r.st    = st;
    r.rbyte = b;
    r.last  = last;
    r.vb    = held_cnt[OUT_CNT_W-1:0];
    r.fb    = free_cnt[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic void ring_empty();
    rd_ptr   = 0;
    wr_ptr   = 0;
    held_cnt = 0;
    free_cnt = DEPTH_DEF;
    blk_open = 1'b0;
    blk_left = 0;
  endfunction

  // Work out the results of one transfer into run_res; return their number.
  function automatic int ring_predict(cmd_t c);
    logic st;
    int   pos;
    int   n;
    st = ST_OK;
    n  = 1;
    case (c.action)
      ACT_WRITE: begin
        if (c.first) begin
          // hand back what is left of the old reservation first
          free_cnt += blk_left;
          blk_left = 0;
          if (int'(c.blen) > free_cnt) begin
            blk_open = 1'b0;
            st = ST_REFUSED;
          end else begin
            blk_open = 1'b1;
            free_cnt -= int'(c.blen);
            blk_left = int'(c.blen);
          end
        end
        if (st == ST_OK) begin
          if (!blk_open) begin
            st = ST_REFUSED;
          end else if (blk_left == 0) begin
            st = c.first ? ST_OK : ST_REFUSED;
          end else begin
            ring_mem[wr_ptr] = c.data;
            wr_ptr = (wr_ptr + 1) % DEPTH_DEF;
            if (wr_ptr == 0) wraps++;
            held_cnt++;
            blk_left--;
          end
        end
      end
      ACT_CONSUME: begin
        if (int'(c.skip) > held_cnt) begin
          st = ST_REFUSED;
        end else begin
          rd_ptr = (rd_ptr + int'(c.skip)) % DEPTH_DEF;
          held_cnt -= int'(c.skip);
          free_cnt += int'(c.skip);
        end
      end
      ACT_PEEK: begin
        if (c.plen == 0 || int'(c.plen) > MAX_PEEK_DEF ||
            int'(c.poff) + int'(c.plen) > held_cnt) begin
          st = ST_REFUSED;
        end else begin
          n = int'(c.plen);
          peek_runs++;
          for (int i = 0; i < n; i++) begin
            pos = (rd_ptr + int'(c.poff) + i) % DEPTH_DEF;
            run_res[i] = mk_res(ST_OK, ring_mem[pos], i == n - 1);
          end
        end
      end
      ACT_CLEAR: ring_empty();
      ACT_STATUS: ;
      default: st = ST_REFUSED;
    endcase
    if (st == ST_REFUSED) refusals++;
    if (n == 1 && !(c.action == ACT_PEEK && st == ST_OK)) run_res[0] = mk_res(st, '0, 1'b1);
    return n;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.action = ACTION_W'($urandom_range(0, 7));
    c.data   = BYTE_W'($urandom_range(0, 255));
    c.first  = 1'($urandom_range(0, 1));
    c.blen   = IN_CNT_W'($urandom_range(0, 8191));
    c.skip   = IN_CNT_W'($urandom_range(0, 8191));
    c.poff   = IN_CNT_W'($urandom_range(0, 8191));
    c.plen   = PLEN_W'($urandom_range(0, 127));
    return c;
  endfunction

  function automatic int min_int(int a, int b);
    return (a < b) ? a : b;
  endfunction

  task automatic note_fault(string what, res_t want, res_t got);
    faults++;
    if (faults <= 10) begin
      $display("%0t MISMATCH %s: exp st=%0d byte=%02h last=%0d valid=%0d free=%0d",
               $time, what, want.st, want.rbyte, want.last, want.vb, want.fb);
      $display("    got st=%0d byte=%02h last=%0d valid=%0d free=%0d",
               got.st, got.rbyte, got.last, got.vb, got.fb);
    end
  endtask

  // Offer one transfer, hold it until taken, then log what it must produce.
  task automatic offer(cmd_t c, bit typed = 1'b0, res_t fixed = '0);
    int n;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, c.plen, c.poff, c.skip, c.blen, c.data};
    in_tuser  <= {c.first, c.action};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_in++;
    n = ring_predict(c);
    if (typed) begin
      due_results.push_back(fixed);
    end else begin
      for (int i = 0; i < n; i++) due_results.push_back(run_res[i]);
    end
  endtask

  task automatic sender_pause();
    int g;
    g = tx_steady ? 0 : pause_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send(logic [ACTION_W-1:0] act, int data = 0, bit first = 0, int blen = 0,
                      int skip = 0, int poff = 0, int plen = 0);
    cmd_t c;
    c = rand_cmd();
    c.action = act;
    c.data   = BYTE_W'(data);
    c.first  = first;
    c.blen   = IN_CNT_W'(blen);
    c.skip   = IN_CNT_W'(skip);
    c.poff   = IN_CNT_W'(poff);
    c.plen   = PLEN_W'(plen);
    offer(c);
    sender_pause();
  endtask

  task automatic row(logic [ACTION_W-1:0] act, int data, bit first, int blen, int skip,
                     int poff, int plen, bit typed = 0, logic st = ST_OK, int vb = 0,
                     int fb = 0);
    row_t r;
    r.c.action    = act;
    r.c.data      = BYTE_W'(data);
    r.c.first     = first;
    r.c.blen      = IN_CNT_W'(blen);
    r.c.skip      = IN_CNT_W'(skip);
    r.c.poff      = IN_CNT_W'(poff);
    r.c.plen      = PLEN_W'(plen);
    r.typed       = typed;
    r.fixed.st    = st;
    r.fixed.rbyte = '0;
    r.fixed.last  = 1'b1;
    r.fixed.vb    = OUT_CNT_W'(vb);
    r.fixed.fb    = OUT_CNT_W'(fb);
    dir_rows.push_back(r);
  endtask

  task automatic write_block(int len, int body);
    send(ACT_WRITE, $urandom_range(0, 255), 1'b1, len);
    repeat (body) send(ACT_WRITE, $urandom_range(0, 255), 1'b0, $urandom_range(0, 8191));
  endtask

  // Fill the ring completely, then move both pointers across the end of the store.
  task automatic ring_wrap_pass();
    send(ACT_CLEAR);
    write_block(DEPTH_DEF, DEPTH_DEF - 1);
    send(ACT_PEEK, 0, 0, 0, 0, DEPTH_DEF - MAX_PEEK_DEF, MAX_PEEK_DEF);
    send(ACT_WRITE, 8'h77, 1'b1, 1);
    send(ACT_CONSUME, 0, 0, 0, 4000);
    write_block(100, 99);
    send(ACT_PEEK, 0, 0, 0, 0, 60, MAX_PEEK_DEF);
    send(ACT_CONSUME, 0, 0, 0, 150);
    send(ACT_PEEK, 0, 0, 0, 0, 0, 46);
    send(ACT_STATUS);
  endtask

  task automatic random_episode();
    int   r, len, body, room, plen;
    cmd_t c;
    r = $urandom_range(0, 99);
    room = free_cnt + blk_left;
    if (r < 40) begin
      r = $urandom_range(0, 99);
      if (r < 8)       len = $urandom_range(0, 8191);
      else if (r < 16) len = room + $urandom_range(1, 3);
      else if (r < 24) len = room;
      else             len = $urandom_range(0, 24);
      body = (len > 0) ? len - 1 : 0;
      // reserve a lot, write only a little of it
      if (body > 40) body = $urandom_range(0, 40);
      r = $urandom_range(0, 9);
      if (r == 0)      body = $urandom_range(0, body);
      else if (r == 1) body += $urandom_range(1, 2);
      write_block(len, body);
    end else if (r < 62) begin
      if (held_cnt == 0) begin
        send(ACT_PEEK, 0, 0, 0, 0, $urandom_range(0, 3), $urandom_range(1, 4));
      end else begin
        plen = ($urandom_range(0, 6) == 0) ? min_int(MAX_PEEK_DEF, held_cnt)
                                           : $urandom_range(1, min_int(MAX_PEEK_DEF, held_cnt));
        send(ACT_PEEK, 0, 0, 0, 0, $urandom_range(0, held_cnt - plen), plen);
      end
    end else if (r < 77) begin
      if ($urandom_range(0, 9) == 0) send(ACT_CONSUME, 0, 0, 0, held_cnt);
      else send(ACT_CONSUME, 0, 0, 0, $urandom_range(0, min_int(held_cnt, 16)));
    end else if (r < 82) begin
      send(ACT_STATUS);
    end else if (r < 85) begin
      send(ACT_CLEAR);
    end else begin
      c = rand_cmd();
      offer(c);
      sender_pause();
    end
  endtask

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin
    int g;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        held_off += HOLD_CYCLES;
        hold_rx = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_tready <= 1'b1;
        repeat (40) @(posedge clk);
      end else begin
        g = pause_len();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.st    = out_tuser;
      got.rbyte = out_tdata[7:0];
      got.last  = out_tlast;
      got.vb    = out_tdata[20:8];
      got.fb    = out_tdata[33:21];
      if (due_results.size() == 0) begin
        note_fault("unexpected transfer", '0, got);
      end else begin
        want = due_results.pop_front();
        checked++;
        if (got.st !== want.st || got.rbyte !== want.rbyte || got.last !== want.last ||
            got.vb !== want.vb || got.fb !== want.fb)
          note_fault("result", want, got);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", due_results.size());
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int start;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    ring_empty();
    foreach (ring_mem[i]) ring_mem[i] = '0;

    // after reset, extremes, every action and the refusal cases
    row(ACT_STATUS,  0,     0, 0,    0,    0,    0,   1, ST_OK,      0, 4096);
    row(ACT_CONSUME, 0,     0, 0,    1,    0,    0,   1, ST_REFUSED, 0, 4096);
    row(ACT_PEEK,    0,     0, 0,    0,    0,    1,   1, ST_REFUSED, 0, 4096);
    row(ACT_WRITE,   8'hFF, 1, 8191, 0,    0,    0,   1, ST_REFUSED, 0, 4096);
    row(ACT_WRITE,   8'h00, 0, 0,    0,    0,    0,   1, ST_REFUSED, 0, 4096);
    row(ACT_WRITE,   8'h12, 1, 0,    0,    0,    0,   1, ST_OK,      0, 4096);
    row(ACT_WRITE,   8'h34, 0, 0,    0,    0,    0,   1, ST_REFUSED, 0, 4096);
    row(ACT_WRITE,   8'hFF, 1, 4096, 0,    0,    0,   1, ST_OK,      1, 0);
    row(ACT_WRITE,   8'h00, 0, 0,    0,    0,    0,   1, ST_OK,      2, 0);
    row(ACT_WRITE,   8'hA5, 1, 3,    0,    0,    0);
    row(ACT_WRITE,   8'h5A, 0, 0,    0,    0,    0);
    row(ACT_WRITE,   8'h3C, 0, 0,    0,    0,    0);
    row(ACT_WRITE,   8'h81, 0, 0,    0,    0,    0);
    row(ACT_PEEK,    0,     0, 0,    0,    0,    5);
    row(ACT_PEEK,    0,     0, 0,    0,    0,    0);
    row(ACT_PEEK,    0,     0, 0,    0,    0,    127);
    row(ACT_PEEK,    0,     0, 0,    0,    8191, 1);
    row(ACT_PEEK,    0,     0, 0,    0,    4,    1);
    row(ACT_CONSUME, 0,     0, 0,    6,    0,    0);
    row(ACT_CONSUME, 0,     0, 0,    8191, 0,    0);
    row(ACT_CONSUME, 0,     0, 0,    0,    0,    0);
    row(ACT_CONSUME, 0,     0, 0,    2,    0,    0);
    row(ACT_RSVD_LO, 0,     0, 0,    0,    0,    0);
    row(ACT_RSVD_MID, 0,    0, 0,    0,    0,    0);
    row(ACT_RSVD_HI, 0,     1, 0,    0,    0,    0);
    row(ACT_WRITE,   8'h11, 1, 10,   0,    0,    0);
    row(ACT_CLEAR,   0,     0, 0,    0,    0,    0,   1, ST_OK,      0, 4096);
    row(ACT_WRITE,   8'h22, 0, 0,    0,    0,    0,   1, ST_REFUSED, 0, 4096);
    row(ACT_PEEK,    0,     0, 0,    0,    0,    1,   1, ST_REFUSED, 0, 4096);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].fixed);
      sender_pause();
    end

    ring_wrap_pass();

    start = items_in;
    while (items_in - start < RAND_ITEMS) begin
      if (items_in - start >= RAND_ITEMS / 2 && held_off == 0 && !hold_rx) begin
        // stall the receiver and keep offering until the input backs up
        hold_rx   = 1'b1;
        tx_steady = 1'b1;
        repeat (20) random_episode();
      end
      tx_steady = ($urandom_range(0, 7) == 0);
      random_episode();
    end
    tx_steady = 1'b0;
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input transfers, %0d checked results, %0d peeks, %0d refusals",
             items_in, checked, peek_runs, refusals);
    $display("write pointer crossed the end of the store %0d time(s); receiver held off %0d cycles",
             wraps, held_off);
    if (faults == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", faults);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- byte_ring_buffer_peek_skip.f -----
rtl/core/brbps_pkg.sv
rtl/core/brbps_front.sv
rtl/core/brbps_queue.sv
rtl/core/brbps_back.sv
rtl/core/byte_ring_buffer_peek_skip.sv
tb/tb_top.sv
